### hw/rtl/idst_pkg.sv
// Shared constants, action codes and the result word type of the id set table.
// Depends on nothing; the interfaces, the sequencer and the top level use it by scoped names.
package idst_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int ACTION_W = 3;
    localparam int IDENT_W  = 32;
    localparam int ENTRY_W  = 31;
    localparam int POS_W    = 8;
    localparam int FILL_W   = 7;

    localparam logic [ACTION_W-1:0] ACT_ADD     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DEL_ID  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DEL_POS = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ    = 3'd4;

    localparam logic [IDENT_W-1:0] NONE_IDENT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                      status;
        logic                      found;
        logic signed [IDENT_W-1:0] read_ident;
        logic [FILL_W-1:0]         fill_count;
    } result_t;

endpackage

### hw/rtl/idst_in_if.sv
// Request channel of the id set table: valid/ready handshake and the request word.
// Depends on idst_pkg for the field widths.
interface idst_in_if;
    logic                                valid;
    logic                                ready;
    logic [idst_pkg::ACTION_W-1:0]       action;
    logic signed [idst_pkg::IDENT_W-1:0] ident;
    logic [idst_pkg::POS_W-1:0]          position;

    modport source (output valid, action, ident, position, input ready);
    modport sink (input valid, action, ident, position, output ready);
endinterface

### hw/rtl/idst_out_if.sv
// Result channel of the id set table: valid/ready handshake and the result word.
// Depends on idst_pkg for the field widths.
interface idst_out_if;
    logic                                valid;
    logic                                ready;
    logic                                status;
    logic                                found;
    logic signed [idst_pkg::IDENT_W-1:0] read_ident;
    logic [idst_pkg::FILL_W-1:0]         fill_count;

    modport source (output valid, status, found, read_ident, fill_count, input ready);
    modport sink (input valid, status, found, read_ident, fill_count, output ready);
endinterface

### hw/rtl/idst_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module idst_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/idst_seq.sv
// Sequencer of the id set table: decodes a request, drives the entry RAM and runs the
// shared compare/index unit over the stored entries. Depends on idst_pkg and idst_in_if.
module idst_seq #(
    parameter int CAPACITY = idst_pkg::DEFAULT_CAPACITY,
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    idst_in_if.sink                        request,
    output idst_pkg::result_t              word,
    output logic                           word_load,
    input  logic                           word_free,
    output logic                           ram_wr_en,
    output logic [IDX_W-1:0]               ram_wr_addr,
    output logic [idst_pkg::ENTRY_W-1:0]   ram_wr_data,
    output logic                           ram_rd_en,
    output logic [IDX_W-1:0]               ram_rd_addr,
    input  logic [idst_pkg::ENTRY_W-1:0]   ram_rd_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > idst_pkg::POS_W) ? CNT_W : idst_pkg::POS_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_RDATA  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]                          state_reg, state_next;
    logic [idst_pkg::ACTION_W-1:0]       act_reg, act_next;
    logic [idst_pkg::ENTRY_W-1:0]        id_reg, id_next;
    logic                                neg_reg, neg_next;
    logic [idst_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [IDX_W-1:0]                    idx_reg, idx_next;
    logic [IDX_W-1:0]                    slot_reg, slot_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic                                status_reg, status_next;
    logic                                found_reg, found_next;
    logic [idst_pkg::IDENT_W-1:0]        read_reg, read_next;

    logic                                pos_ok;
    logic [IDX_W-1:0]                    pos_idx;
    logic [IDX_W-1:0]                    last_idx;
    logic [CNT_W-1:0]                    idx_inc;
    logic                                hit;

    assign pos_ok   = CMP_W'(pos_reg) < CMP_W'(count_reg);
    assign pos_idx  = pos_reg[IDX_W-1:0];
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign hit      = (ram_rd_data == id_reg);

    assign request.ready = (state_reg == S_IDLE);

    assign word.status     = status_reg;
    assign word.found      = found_reg;
    assign word.read_ident = read_reg;
    assign word.fill_count = idst_pkg::FILL_W'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        id_next     = id_reg;
        neg_next    = neg_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        status_next = status_reg;
        found_next  = found_reg;
        read_next   = read_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = last_idx;
        word_load   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    act_next    = request.action;
                    id_next     = request.ident[idst_pkg::ENTRY_W-1:0];
                    neg_next    = request.ident[idst_pkg::IDENT_W-1];
                    pos_next    = request.position;
                    status_next = 1'b1;
                    found_next  = 1'b0;
                    read_next   = idst_pkg::NONE_IDENT;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (act_reg)
                    idst_pkg::ACT_ADD:
                    begin
                        if (!neg_reg && (count_reg < CNT_W'(CAPACITY)))
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = count_reg[IDX_W-1:0];
                            ram_wr_data = id_reg;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = 1'b0;
                        end
                    end
                    idst_pkg::ACT_DEL_ID:
                    begin
                        if (!neg_reg && (count_reg != '0))
                        begin
                            idx_next    = '0;
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    idst_pkg::ACT_QUERY:
                    begin
                        if (!neg_reg && (id_reg != '0))
                        begin
                            status_next = 1'b0;
                            if (count_reg != '0)
                            begin
                                idx_next    = '0;
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                state_next  = S_SCAN;
                            end
                        end
                    end
                    idst_pkg::ACT_DEL_POS:
                    begin
                        if (pos_ok)
                        begin
                            slot_next   = pos_idx;
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = last_idx;
                            state_next  = S_MOVE;
                        end
                    end
                    idst_pkg::ACT_READ:
                    begin
                        if (pos_ok)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = pos_idx;
                            state_next  = S_RDATA;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                // The RAM output holds the entry at idx_reg; the next address is
                // issued in the same cycle so that one entry is checked per cycle.
                if (hit)
                begin
                    if (act_reg == idst_pkg::ACT_QUERY)
                    begin
                        found_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        slot_next   = idx_reg;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = last_idx;
                        state_next  = S_MOVE;
                    end
                end
                else if (idx_inc < count_reg)
                begin
                    idx_next    = idx_inc[IDX_W-1:0];
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_inc[IDX_W-1:0];
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MOVE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = slot_reg;
                ram_wr_data = ram_rd_data;
                count_next  = count_reg - CNT_W'(1);
                status_next = 1'b0;
                state_next  = S_DONE;
            end
            S_RDATA:
            begin
                read_next   = {1'b0, ram_rd_data};
                status_next = 1'b0;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (word_free)
                begin
                    word_load  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        id_reg     <= id_next;
        neg_reg    <= neg_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        read_reg   <= read_next;
    end

endmodule

### hw/rtl/id_set_table.sv
// Top level of the id set table: entry RAM, sequencer and the result word register.
// Depends on idst_pkg, idst_in_if, idst_out_if, idst_ram and idst_seq.
//
// The block keeps an unordered table of up to CAPACITY identifiers in a single RAM and
// serves one request word at a time. Add and every request refused at decode pass from
// the decode state to the done state and from there into the result register; read and
// delete by position pass through the read-data or the move state on the way. Delete by
// id and membership query scan the stored entries through the single RAM read port, one
// entry per cycle, before the done state. A new request word is accepted while the
// previous result word still waits in the output register.
module id_set_table #(
    parameter int CAPACITY = idst_pkg::DEFAULT_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    idst_in_if.sink     request,
    idst_out_if.source  result
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    idst_pkg::result_t                done_word;
    logic                             done_load;
    logic                             done_free;
    logic                             ram_wr_en;
    logic [IDX_W-1:0]                 ram_wr_addr;
    logic [idst_pkg::ENTRY_W-1:0]     ram_wr_data;
    logic                             ram_rd_en;
    logic [IDX_W-1:0]                 ram_rd_addr;
    logic [idst_pkg::ENTRY_W-1:0]     ram_rd_data;

    logic                             out_valid_reg;
    idst_pkg::result_t                out_word_reg;

    idst_ram #(
        .WIDTH (idst_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    idst_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .word        (done_word),
        .word_load   (done_load),
        .word_free   (done_free),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    assign done_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_load)
        begin
            out_word_reg <= done_word;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.status     = out_word_reg.status;
    assign result.found      = out_word_reg.found;
    assign result.read_ident = out_word_reg.read_ident;
    assign result.fill_count = out_word_reg.fill_count;

endmodule
